FILE: design/smu_pkg.sv
package smu_pkg;

  localparam int NAME_BYTES  = 10;
  localparam int PHONE_BYTES = 10;

  localparam logic [7:0] CODE_INS = 8'h49;
  localparam logic [7:0] CODE_CHG = 8'h43;
  localparam logic [7:0] CODE_DEL = 8'h44;

  function automatic logic [63:0] low_mask(input int bytes);
    if (bytes >= 8) begin
      return '1;
    end
    return (64'd1 << (8 * bytes)) - 64'd1;
  endfunction

  function automatic logic [15:0] high_mask(input int bytes);
    if (bytes <= 8) begin
      return '0;
    end
    if (bytes >= 10) begin
      return '1;
    end
    return (16'd1 << (8 * (bytes - 8))) - 16'd1;
  endfunction

  localparam logic [63:0] NAME_LO_MASK  = low_mask(NAME_BYTES);
  localparam logic [15:0] NAME_HI_MASK  = high_mask(NAME_BYTES);
  localparam logic [63:0] PHONE_LO_MASK = low_mask(PHONE_BYTES);
  localparam logic [15:0] PHONE_HI_MASK = high_mask(PHONE_BYTES);

  typedef enum logic [1:0] {
    KIND_TRANS_REC  = 2'd0,
    KIND_MASTER_REC = 2'd1,
    KIND_TRANS_END  = 2'd2,
    KIND_MASTER_END = 2'd3
  } smu_kind_t;

  typedef enum logic [1:0] {
    CLS_INS = 2'd0,
    CLS_CHG = 2'd1,
    CLS_DEL = 2'd2,
    CLS_BAD = 2'd3
  } smu_cls_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_DUP       = 2'd1,
    ERR_NO_MASTER = 2'd2,
    ERR_BAD_CODE  = 2'd3
  } smu_err_t;

  typedef enum logic [1:0] {
    WANT_TRANS  = 2'd0,
    WANT_MASTER = 2'd1,
    WANT_NONE   = 2'd2
  } smu_want_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] rec_key;
    logic [7:0]         update_code;
    logic [63:0]        name_low;
    logic [15:0]        name_high;
    logic [63:0]        phone_low;
    logic [15:0]        phone_high;
  } smu_in_t;

  typedef struct packed {
    logic               write_valid;
    logic signed [31:0] out_key;
    logic [63:0]        out_name_low;
    logic [15:0]        out_name_high;
    logic [63:0]        out_phone_low;
    logic [15:0]        out_phone_high;
    logic [1:0]         error_kind;
    logic [1:0]         want_next;
  } smu_out_t;

  typedef struct packed {
    logic [63:0] name_lo;
    logic [15:0] name_hi;
    logic [63:0] phone_lo;
    logic [15:0] phone_hi;
  } smu_rec_t;

  // classified word passed from front to back
  typedef struct packed {
    smu_kind_t          kind;
    smu_cls_t           cls;
    logic signed [31:0] key;
    smu_rec_t           rec;
  } smu_item_t;

endpackage

FILE: design/smu_front.sv
module smu_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  smu_pkg::smu_in_t   in_data,
  input  logic               q_pop,
  output logic               q_valid,
  output smu_pkg::smu_item_t q_item
);

  smu_pkg::smu_item_t item_nxt;
  smu_pkg::smu_item_t mem_r [2];
  logic               wp_r;
  logic               wp_nxt;
  logic               rp_r;
  logic               rp_nxt;
  logic [1:0]         cnt_r;
  logic [1:0]         cnt_nxt;
  logic               push_acc;
  logic               pop_acc;

  always_comb begin
    item_nxt = '0;
    item_nxt.kind = smu_pkg::smu_kind_t'(in_data.req_type);
    priority if (in_data.update_code == smu_pkg::CODE_INS) begin
      item_nxt.cls = smu_pkg::CLS_INS;
    end else if (in_data.update_code == smu_pkg::CODE_CHG) begin
      item_nxt.cls = smu_pkg::CLS_CHG;
    end else if (in_data.update_code == smu_pkg::CODE_DEL) begin
      item_nxt.cls = smu_pkg::CLS_DEL;
    end else begin
      item_nxt.cls = smu_pkg::CLS_BAD;
    end
    item_nxt.key          = in_data.rec_key;
    item_nxt.rec.name_lo  = in_data.name_low & smu_pkg::NAME_LO_MASK;
    item_nxt.rec.name_hi  = in_data.name_high & smu_pkg::NAME_HI_MASK;
    item_nxt.rec.phone_lo = in_data.phone_low & smu_pkg::PHONE_LO_MASK;
    item_nxt.rec.phone_hi = in_data.phone_high & smu_pkg::PHONE_HI_MASK;
  end

  assign full     = (cnt_r == 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];
  assign push_acc = push && !full;
  assign pop_acc  = q_pop && q_valid;

  always_comb begin
    wp_nxt  = push_acc ? ~wp_r : wp_r;
    rp_nxt  = pop_acc ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push_acc} - {1'b0, pop_acc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_acc) begin
      mem_r[wp_r] <= item_nxt;
    end
  end

endmodule

FILE: design/smu_back.sv
module smu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  smu_pkg::smu_item_t q_item,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output smu_pkg::smu_out_t  out_data
);

  // merge state
  logic               th_r, th_nxt, td_r, td_nxt;
  logic               mh_r, mh_nxt, md_r, md_nxt;
  smu_pkg::smu_cls_t  tcls_r;
  logic signed [31:0] tkey_r, mkey_r;
  smu_pkg::smu_rec_t  trec_r, mrec_r;

  // result queue
  smu_pkg::smu_out_t  omem_r [2];
  logic               owp_r, orp_r;
  logic [1:0]         ocnt_r, ocnt_nxt;
  logic               opop_acc;
  logic               room;

  logic               ld_t, ld_m;
  logic               th1, td1, mh1, md1;
  logic               clr_t, clr_m;
  smu_pkg::smu_cls_t  tcls_e;
  logic signed [31:0] tkey_e, mkey_e;
  smu_pkg::smu_rec_t  trec_e, mrec_e;
  smu_pkg::smu_out_t  res;

  assign empty    = (ocnt_r == 2'd0);
  assign out_data = omem_r[orp_r];
  assign opop_acc = pop && !empty;
  assign room     = (ocnt_r != 2'd2) || opop_acc;
  assign q_pop    = q_valid && room;

  always_comb begin
    ld_t   = (q_item.kind == smu_pkg::KIND_TRANS_REC) && !th_r && !td_r;
    ld_m   = (q_item.kind == smu_pkg::KIND_MASTER_REC) && !mh_r && !md_r;
    th1    = th_r || ld_t;
    mh1    = mh_r || ld_m;
    td1    = td_r || ((q_item.kind == smu_pkg::KIND_TRANS_END) && !th_r);
    md1    = md_r || ((q_item.kind == smu_pkg::KIND_MASTER_END) && !mh_r);
    tcls_e = ld_t ? q_item.cls : tcls_r;
    tkey_e = ld_t ? q_item.key : tkey_r;
    trec_e = ld_t ? q_item.rec : trec_r;
    mkey_e = ld_m ? q_item.key : mkey_r;
    mrec_e = ld_m ? q_item.rec : mrec_r;
  end

  // one merge decision per word
  always_comb begin
    logic emit_m;
    logic emit_t;
    logic lone;
    emit_m = 1'b0;
    emit_t = 1'b0;
    lone   = 1'b0;
    clr_t  = 1'b0;
    clr_m  = 1'b0;
    res    = '0;
    priority if (mh1 && th1) begin
      priority if ($signed(mkey_e) < $signed(tkey_e)) begin
        emit_m = 1'b1;
      end else if (mkey_e == tkey_e) begin
        unique case (tcls_e)
          smu_pkg::CLS_INS: begin
            res.error_kind = smu_pkg::ERR_DUP;
            clr_t = 1'b1;
          end
          smu_pkg::CLS_CHG: begin
            emit_t = 1'b1;
            clr_m  = 1'b1;
          end
          smu_pkg::CLS_DEL: begin
            clr_t = 1'b1;
            clr_m = 1'b1;
          end
          default: begin
            res.error_kind = smu_pkg::ERR_BAD_CODE;
            clr_t = 1'b1;
          end
        endcase
      end else begin
        lone = 1'b1;
      end
    end else if (mh1 && td1) begin
      emit_m = 1'b1;
    end else if (th1 && md1) begin
      lone = 1'b1;
    end else begin
      lone = 1'b0;
    end

    // transaction with no master of its key
    if (lone) begin
      unique case (tcls_e)
        smu_pkg::CLS_INS: emit_t = 1'b1;
        smu_pkg::CLS_CHG, smu_pkg::CLS_DEL: res.error_kind = smu_pkg::ERR_NO_MASTER;
        default: res.error_kind = smu_pkg::ERR_BAD_CODE;
      endcase
      clr_t = 1'b1;
    end

    if (emit_m) begin
      clr_m              = 1'b1;
      res.write_valid    = 1'b1;
      res.out_key        = mkey_e;
      res.out_name_low   = mrec_e.name_lo;
      res.out_name_high  = mrec_e.name_hi;
      res.out_phone_low  = mrec_e.phone_lo;
      res.out_phone_high = mrec_e.phone_hi;
    end
    if (emit_t) begin
      clr_t              = 1'b1;
      res.write_valid    = 1'b1;
      res.out_key        = tkey_e;
      res.out_name_low   = trec_e.name_lo;
      res.out_name_high  = trec_e.name_hi;
      res.out_phone_low  = trec_e.phone_lo;
      res.out_phone_high = trec_e.phone_hi;
    end

    th_nxt = th1 && !clr_t;
    mh_nxt = mh1 && !clr_m;
    td_nxt = td1;
    md_nxt = md1;

    priority if (!th_nxt && !td1) begin
      res.want_next = smu_pkg::WANT_TRANS;
    end else if (!mh_nxt && !md1) begin
      res.want_next = smu_pkg::WANT_MASTER;
    end else begin
      res.want_next = smu_pkg::WANT_NONE;
    end
  end

  assign ocnt_nxt = ocnt_r + {1'b0, q_pop} - {1'b0, opop_acc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      th_r   <= 1'b0;
      td_r   <= 1'b0;
      mh_r   <= 1'b0;
      md_r   <= 1'b0;
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (q_pop) begin
        th_r  <= th_nxt;
        td_r  <= td_nxt;
        mh_r  <= mh_nxt;
        md_r  <= md_nxt;
        owp_r <= ~owp_r;
      end
      if (opop_acc) begin
        orp_r <= ~orp_r;
      end
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && ld_t) begin
      tcls_r <= q_item.cls;
      tkey_r <= q_item.key;
      trec_r <= q_item.rec;
    end
    if (q_pop && ld_m) begin
      mkey_r <= q_item.key;
      mrec_r <= q_item.rec;
    end
    if (q_pop) begin
      omem_r[owp_r] <= res;
    end
  end

endmodule

FILE: design/sorted_master_update_merge.sv
// Sequential master-file update merge. Master records and transactions arrive
// on one input queue, each word tagged by req_type, and every accepted word
// yields exactly one result word; want_next in that result names the stream
// to feed next. One word per clock is sustained while the result queue has room
// and out_data is popped: the front decodes the word into a two-entry queue and
// the back makes the single signed key compare and slot update per word, writing
// a two-entry result queue. An accepted word waits in the front queue, then its
// result is registered into the result queue, from which it is popped; the pace
// is set by the back's one-compare-per-word merge step, since each word's decision
// depends on the slots the previous word left.
module sorted_master_update_merge (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  smu_pkg::smu_in_t  in_data,
  output logic              empty,
  input  logic              pop,
  output smu_pkg::smu_out_t out_data
);

  logic               q_valid;
  logic               q_pop;
  smu_pkg::smu_item_t q_item;

  smu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_pop   (q_pop),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  smu_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

FILE: verif/sorted_master_update_merge_test.sv
`timescale 1ns / 100ps

module sorted_master_update_merge_test;
  import smu_pkg::*;

  localparam int LIMIT = 200000;
  localparam int RANDOM_WORDS = 450;
  localparam logic [7:0] NUL_CODE = 8'h00;
  localparam logic [7:0] ALL_ONES_CODE = 8'hFF;
  localparam logic [7:0] LOWER_I_CODE = 8'h69;
  localparam longint KEY_MIN = -64'sd2147483648;
  localparam longint KEY_MAX = 64'sd2147483647;

  class merge_tracker;
    bit m_held, m_done, t_held, t_done;
    logic signed [31:0] m_key, t_key;
    logic [7:0] t_code;
    smu_rec_t m_rec, t_rec;
    smu_out_t pending_results[$];
    int errors, words_in, results_seen, n_written, n_dup, n_no_master, n_bad;

    function smu_want_t wanted();
      if (!t_held && !t_done) begin
        return WANT_TRANS;
      end
      if (!m_held && !m_done) begin
        return WANT_MASTER;
      end
      return WANT_NONE;
    endfunction

    function smu_out_t written(logic signed [31:0] key, smu_rec_t rec);
      smu_out_t r;
      r = '0;
      r.write_valid = 1'b1;
      r.out_key = key;
      r.out_name_low = rec.name_lo;
      r.out_name_high = rec.name_hi;
      r.out_phone_low = rec.phone_lo;
      r.out_phone_high = rec.phone_hi;
      return r;
    endfunction

    // transaction with no master of the same key
    function smu_out_t lone_trans();
      smu_out_t r;
      r = '0;
      if (t_code == CODE_INS) begin
        r = written(t_key, t_rec);
      end else if (t_code == CODE_CHG || t_code == CODE_DEL) begin
        r.error_kind = ERR_NO_MASTER;
      end else begin
        r.error_kind = ERR_BAD_CODE;
      end
      t_held = 1'b0;
      return r;
    endfunction

    function void accept_word(smu_in_t w);
      smu_rec_t rec;
      smu_out_t r;
      rec.name_lo = w.name_low & NAME_LO_MASK;
      rec.name_hi = w.name_high & NAME_HI_MASK;
      rec.phone_lo = w.phone_low & PHONE_LO_MASK;
      rec.phone_hi = w.phone_high & PHONE_HI_MASK;
      r = '0;
      words_in++;
      case (smu_kind_t'(w.req_type))
        KIND_TRANS_REC: begin
          if (!t_held && !t_done) begin
            t_held = 1'b1;
            t_key = w.rec_key;
            t_code = w.update_code;
            t_rec = rec;
          end
        end
        KIND_MASTER_REC: begin
          if (!m_held && !m_done) begin
            m_held = 1'b1;
            m_key = w.rec_key;
            m_rec = rec;
          end
        end
        KIND_TRANS_END: begin
          if (!t_held) t_done = 1'b1;
        end
        default: begin
          if (!m_held) m_done = 1'b1;
        end
      endcase
      if (m_held && t_held) begin
        if (m_key < t_key) begin
          r = written(m_key, m_rec);
          m_held = 1'b0;
        end else if (m_key == t_key) begin
          case (t_code)
            CODE_INS: begin
              r.error_kind = ERR_DUP;
              t_held = 1'b0;
            end
            CODE_CHG: begin
              r = written(t_key, t_rec);
              t_held = 1'b0;
              m_held = 1'b0;
            end
            CODE_DEL: begin
              t_held = 1'b0;
              m_held = 1'b0;
            end
            default: begin
              r.error_kind = ERR_BAD_CODE;
              t_held = 1'b0;
            end
          endcase
        end else begin
          r = lone_trans();
        end
      end else if (m_held && t_done) begin
        r = written(m_key, m_rec);
        m_held = 1'b0;
      end else if (t_held && m_done) begin
        r = lone_trans();
      end
      r.want_next = wanted();
      pending_results.push_back(r);
    endfunction

    function void compare_field(string label, logic [63:0] exp_v, logic [63:0] got_v);
      if (exp_v !== got_v) begin
        errors++;
        if (errors <= 40) begin
          $display("%0t: %s mismatch, expected %h, got %h", $time, label, exp_v, got_v);
        end
      end
    endfunction

    function void check_word(smu_out_t got);
      smu_out_t exp_w;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 40) begin
          $display("%0t: result word with none expected, expected nothing, got %h",
                   $time, got);
        end
        return;
      end
      exp_w = pending_results.pop_front();
      results_seen++;
      compare_field("write_valid", exp_w.write_valid, got.write_valid);
      compare_field("out_key", exp_w.out_key, got.out_key);
      compare_field("out_name_low", exp_w.out_name_low, got.out_name_low);
      compare_field("out_name_high", exp_w.out_name_high, got.out_name_high);
      compare_field("out_phone_low", exp_w.out_phone_low, got.out_phone_low);
      compare_field("out_phone_high", exp_w.out_phone_high, got.out_phone_high);
      compare_field("error_kind", exp_w.error_kind, got.error_kind);
      compare_field("want_next", exp_w.want_next, got.want_next);
      if (exp_w.write_valid) n_written++;
      case (smu_err_t'(exp_w.error_kind))
        ERR_DUP:       n_dup++;
        ERR_NO_MASTER: n_no_master++;
        ERR_BAD_CODE:  n_bad++;
        default: ;
      endcase
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  smu_in_t in_data = '0;
  smu_out_t out_data;

  merge_tracker sb = new();
  bit steady = 1'b0;
  bit trans_first;
  longint m_cursor = KEY_MIN;
  longint t_cursor = KEY_MIN;
  int cycles = 0;

  sorted_master_update_merge dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    pop <= steady || ($urandom_range(0, 99) >= 21);
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) sb.check_word(out_data);
  end

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  function automatic smu_in_t make_word(smu_kind_t kind, longint key, logic [7:0] code);
    smu_in_t w;
    w.req_type = kind;
    w.rec_key = key[31:0];
    w.update_code = code;
    w.name_low = {$urandom, $urandom};
    w.name_high = 16'($urandom);
    w.phone_low = {$urandom, $urandom};
    w.phone_high = 16'($urandom);
    return w;
  endfunction

  function automatic logic [7:0] pick_code();
    int pick;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 35) return CODE_INS;
    if (pick < 60) return CODE_CHG;
    if (pick < 85) return CODE_DEL;
    do begin
      c = 8'($urandom);
    end while (c == CODE_INS || c == CODE_CHG || c == CODE_DEL);
    return c;
  endfunction

  // non-decreasing keys; often land on the other stream's key so they meet
  function automatic longint next_key(longint cur, longint other);
    int pick;
    longint k;
    pick = $urandom_range(0, 99);
    if (pick < 35 && other >= cur) begin
      k = other;
    end else if (pick < 45) begin
      k = cur + longint'($urandom_range(1, 1 << 27));
    end else begin
      k = cur + longint'($urandom_range(0, 2));
    end
    if (k > KEY_MAX) k = KEY_MAX;
    return k;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(smu_in_t w);
    while (!steady && $urandom_range(0, 99) < 21) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_data <= w;
    do begin
      @(posedge clk);
    end while (full);
    sb.accept_word(w);
    @(negedge clk);
  endtask

  task automatic feed(smu_kind_t kind, longint key, logic [7:0] code);
    send_word(make_word(kind, key, code));
  endtask

  task automatic feed_flat(smu_kind_t kind, longint key, logic [7:0] code, logic fill);
    smu_in_t w;
    w = make_word(kind, key, code);
    w.name_low = {64{fill}};
    w.name_high = {16{fill}};
    w.phone_low = {64{fill}};
    w.phone_high = {16{fill}};
    send_word(w);
  endtask

  task automatic feed_wanted();
    if (sb.wanted() == WANT_MASTER) begin
      m_cursor = next_key(m_cursor, t_cursor);
      feed(KIND_MASTER_REC, m_cursor, pick_code());
    end else begin
      t_cursor = next_key(t_cursor, m_cursor);
      feed(KIND_TRANS_REC, t_cursor, pick_code());
    end
  endtask

  // words that the block should ignore or that arrive unasked
  task automatic feed_noise();
    bit end_marker;
    end_marker = $urandom_range(0, 2) == 0;
    if (sb.t_held && (!sb.m_held || $urandom_range(0, 1))) begin
      if (end_marker) feed(KIND_TRANS_END, longint'($urandom), pick_code());
      else feed(KIND_TRANS_REC, longint'($urandom), pick_code());
    end else if (sb.m_held) begin
      if (end_marker) feed(KIND_MASTER_END, longint'($urandom), pick_code());
      else feed(KIND_MASTER_REC, longint'($urandom), pick_code());
    end else begin
      m_cursor = next_key(m_cursor, t_cursor);
      feed(KIND_MASTER_REC, m_cursor, pick_code());
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // extreme keys, full and held slots, every code path
    feed(KIND_MASTER_REC, KEY_MIN, pick_code());
    feed(KIND_MASTER_REC, KEY_MAX, pick_code());
    feed(KIND_MASTER_END, 0, pick_code());
    feed_flat(KIND_TRANS_REC, KEY_MAX, CODE_INS, 1'b0);
    feed(KIND_TRANS_END, 0, pick_code());
    feed(KIND_TRANS_REC, 0, CODE_CHG);
    feed(KIND_MASTER_REC, KEY_MAX, pick_code());
    feed_flat(KIND_TRANS_REC, KEY_MAX, CODE_CHG, 1'b1);
    feed(KIND_TRANS_REC, -1, CODE_CHG);
    feed(KIND_MASTER_REC, 0, pick_code());
    feed(KIND_TRANS_REC, 0, CODE_DEL);
    feed(KIND_TRANS_REC, 5, CODE_INS);
    feed(KIND_MASTER_REC, 10, pick_code());
    feed(KIND_TRANS_REC, 10, NUL_CODE);
    feed(KIND_TRANS_REC, 20, CODE_DEL);
    feed(KIND_MASTER_REC, 20, pick_code());
    feed(KIND_TRANS_REC, 30, ALL_ONES_CODE);
    feed(KIND_MASTER_REC, 40, pick_code());
    feed(KIND_TRANS_REC, 40, LOWER_I_CODE);
    feed(KIND_TRANS_REC, 50, CODE_INS);
    feed(KIND_MASTER_REC, 50, pick_code());
    feed(KIND_TRANS_REC, 50, CODE_CHG);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      steady = (i >= 120 && i < 220);
      if (i == 300) wait_drained();
      if ($urandom_range(0, 99) < 12) feed_noise();
      else feed_wanted();
    end
    steady = 1'b0;

    // close one stream, drain the other, then poke the finished block
    trans_first = $urandom_range(0, 1);
    if (trans_first) begin
      while (sb.wanted() != WANT_TRANS) feed_wanted();
      feed(KIND_TRANS_END, 0, pick_code());
      repeat (8) feed_wanted();
      feed(KIND_TRANS_REC, longint'($urandom), CODE_INS);
      feed(KIND_MASTER_END, 0, pick_code());
    end else begin
      while (sb.wanted() != WANT_MASTER) feed_wanted();
      feed(KIND_MASTER_END, 0, pick_code());
      repeat (8) feed_wanted();
      feed(KIND_MASTER_REC, longint'($urandom), pick_code());
      feed(KIND_TRANS_END, 0, pick_code());
    end
    feed(KIND_TRANS_END, 0, pick_code());
    feed(KIND_MASTER_END, 0, pick_code());
    feed(KIND_TRANS_REC, longint'($urandom), CODE_DEL);
    feed(KIND_MASTER_REC, longint'($urandom), pick_code());

    wait_drained();
    repeat (16) @(posedge clk);
    $display("%0d words in, %0d results: %0d written, %0d dup inserts,",
             sb.words_in, sb.results_seen, sb.n_written, sb.n_dup);
    $display("%0d missing masters, %0d bad codes; %s stream closed first, the other drained",
             sb.n_no_master, sb.n_bad, trans_first ? "transaction" : "master");
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
